[sv/ctl_pkg.sv]
`default_nettype none

package ctl_pkg;

  localparam int ADDR_W = 32;
  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int CACHE_BYTES_DEFAULT = 32768;
  localparam int LINE_BYTES_DEFAULT = 128;

  // one lookup result
  typedef struct packed {
    logic hit;
    logic way;
    logic evicted;
  } ctl_result_t;

  // floor of log2, zero for values below two
  function automatic int floor_log2(input int unsigned v);
    int r;
    r = 0;
    for (int i = 1; i < 32; i++) begin
      if (v >= (32'd1 << i)) begin
        r = i;
      end
    end
    return r;
  endfunction

  // saturating use count increment
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

[sv/ctl_tag_ram.sv]
`default_nettype none

module ctl_tag_ram #(
  parameter int DEPTH = 128,
  parameter int AW = 7,
  parameter int DW = 102
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  input  wire logic          re,
  input  wire logic [AW-1:0] ra,
  output logic      [DW-1:0] rd
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

[sv/ctl_way_select.sv]
`default_nettype none

module ctl_way_select #(
  parameter int TAG_W = 18,
  localparam int EW = 1 + TAG_W + ctl_pkg::COUNT_W
) (
  input  wire logic              two_way,
  input  wire logic              half,
  input  wire logic [TAG_W-1:0]  tag,
  input  wire logic [2*EW-1:0]   row_in,
  output logic      [2*EW-1:0]   row_out,
  output ctl_pkg::ctl_result_t   res
);

  localparam int CW = ctl_pkg::COUNT_W;

  logic             v0, v1;
  logic [TAG_W-1:0] t0, t1;
  logic [CW-1:0]    c0, c1;
  logic             m0, m1;
  logic [EW-1:0]    fill;

  assign v0 = row_in[EW-1];
  assign t0 = row_in[EW-2 -: TAG_W];
  assign c0 = row_in[CW-1:0];
  assign v1 = row_in[2*EW-1];
  assign t1 = row_in[2*EW-2 -: TAG_W];
  assign c1 = row_in[EW+CW-1:EW];

  assign m0 = v0 && (t0 == tag);
  assign m1 = v1 && (t1 == tag);
  assign fill = {1'b1, tag, CW'(1)};

  always_comb begin
    row_out = row_in;
    res = '0;
    if (two_way) begin
      if (m0) begin
        res.hit = 1'b1;
        row_out[EW-1:0] = {v0, t0, ctl_pkg::sat_inc(c0)};
      end else if (m1) begin
        res.hit = 1'b1;
        res.way = 1'b1;
        row_out[2*EW-1:EW] = {v1, t1, ctl_pkg::sat_inc(c1)};
      end else if (!v0) begin
        row_out[EW-1:0] = fill;
      end else if (!v1) begin
        res.way = 1'b1;
        row_out[2*EW-1:EW] = fill;
      end else begin
        // both valid: smaller count goes, way 0 on a tie
        res.evicted = 1'b1;
        if (c1 < c0) begin
          res.way = 1'b1;
          row_out[2*EW-1:EW] = fill;
        end else begin
          row_out[EW-1:0] = fill;
        end
      end
    end else if (!half) begin
      if (m0) begin
        res.hit = 1'b1;
        row_out[EW-1:0] = {v0, t0, ctl_pkg::sat_inc(c0)};
      end else begin
        res.evicted = v0;
        row_out[EW-1:0] = fill;
      end
    end else begin
      if (m1) begin
        res.hit = 1'b1;
        row_out[2*EW-1:EW] = {v1, t1, ctl_pkg::sat_inc(c1)};
      end else begin
        res.evicted = v1;
        row_out[2*EW-1:EW] = fill;
      end
    end
  end

endmodule

`default_nettype wire

[sv/cache_tag_lookup_lfu_unit.sv]
// channel   | signals                        | direction | accepted when
// ----------+--------------------------------+-----------+-------------------------
// lookup    | start, busy, address           | in        | start && !busy
// result    | done, hit, way, evicted        | out       | done (one cycle, no stall)
// config    | cfg_valid, cfg_ready, cfg_data | in        | cfg_valid && cfg_ready
//
// one item per cycle while not busy; the tag row is read at the edge that takes the item,
// the row update, the result registers and done all load at the next edge, so done is high after it
// reset: a clearing pass writes all (CACHE_BYTES / LINE_BYTES + 1) / 2 tag ram rows (128 at the
// defaults) invalid, one row a cycle, busy high meanwhile
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module cache_tag_lookup_lfu_unit #(
  parameter int CACHE_BYTES = ctl_pkg::CACHE_BYTES_DEFAULT,
  parameter int LINE_BYTES = ctl_pkg::LINE_BYTES_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ctl_pkg::ADDR_W-1:0] address,
  output logic                            done,
  output logic                            hit,
  output logic                            way,
  output logic                            evicted,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_data
);

  localparam int AW = ctl_pkg::ADDR_W;
  localparam int CW = ctl_pkg::COUNT_W;

  // geometry
  localparam int NUM_LINES = (CACHE_BYTES / LINE_BYTES > 0) ? CACHE_BYTES / LINE_BYTES : 1;
  localparam bit TWO_WAY_OK = (NUM_LINES >= 2);
  localparam int B = ctl_pkg::floor_log2(LINE_BYTES);
  localparam int SD = ctl_pkg::floor_log2(NUM_LINES);
  localparam int ST = ctl_pkg::floor_log2((NUM_LINES / 2 > 0) ? NUM_LINES / 2 : 1);
  localparam int TAG_W = AW - B - ST;
  localparam int EW = 1 + TAG_W + CW;
  localparam int ROWS = (NUM_LINES + 1) / 2;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [AW-1:0] MASK_D = (AW'(1) << SD) - AW'(1);
  localparam logic [AW-1:0] MASK_T = (AW'(1) << ST) - AW'(1);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  // config register
  logic two_way_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_way_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      two_way_mode <= cfg_data;
    end
  end

  // clearing pass after reset
  logic              clearing;
  logic [ROW_AW-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + ROW_AW'(1);
      if (clr_row == LAST_ROW) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing;

  logic accept;
  assign accept = start && !busy;

  // address split: in two-way mode a row is a set, in direct mode a row holds two sets
  logic [AW-1:0]     line_addr;
  logic [AW-1:0]     set_d;
  logic [AW-1:0]     set_t;
  logic [AW-1:0]     tag_d;
  logic [AW-1:0]     tag_t;
  logic              two_eff;
  logic [ROW_AW-1:0] row_sel;
  logic              half_sel;
  logic [TAG_W-1:0]  tag_sel;

  assign line_addr = address >> B;
  assign set_d = line_addr & MASK_D;
  assign set_t = line_addr & MASK_T;
  assign tag_d = address >> (B + SD);
  assign tag_t = address >> (B + ST);
  // a single-line cache has no second way
  assign two_eff = two_way_mode && TWO_WAY_OK;

  always_comb begin
    if (two_eff) begin
      row_sel = set_t[ROW_AW-1:0];
      half_sel = 1'b0;
      tag_sel = tag_t[TAG_W-1:0];
    end else begin
      row_sel = set_d[ROW_AW:1];
      half_sel = set_d[0];
      tag_sel = tag_d[TAG_W-1:0];
    end
  end

  // lookup stage registers
  logic              s1_valid;
  logic [ROW_AW-1:0] s1_row;
  logic              s1_half;
  logic              s1_two;
  logic [TAG_W-1:0]  s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= row_sel;
      s1_half <= half_sel;
      s1_two <= two_eff;
      s1_tag <= tag_sel;
    end
  end

  // tag ram with write-to-read bypass for back-to-back items on the same row
  logic              wr_en;
  logic [ROW_AW-1:0] wr_addr;
  logic [2*EW-1:0]   wr_data;
  logic [2*EW-1:0]   rd_data;
  logic [2*EW-1:0]   row_new;
  logic              byp_valid;
  logic [2*EW-1:0]   byp_data;
  logic [2*EW-1:0]   row_cur;

  assign wr_en = clearing || s1_valid;
  assign wr_addr = clearing ? clr_row : s1_row;
  assign wr_data = clearing ? '0 : row_new;

  ctl_tag_ram #(
    .DEPTH (ROWS),
    .AW    (ROW_AW),
    .DW    (2 * EW)
  ) u_tag_ram (
    .clk (clk),
    .we  (wr_en),
    .wa  (wr_addr),
    .wd  (wr_data),
    .re  (accept),
    .ra  (row_sel),
    .rd  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= accept && wr_en && (wr_addr == row_sel);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wr_data;
  end

  assign row_cur = byp_valid ? byp_data : rd_data;

  // hit check, victim choice and row update
  ctl_pkg::ctl_result_t res;

  ctl_way_select #(
    .TAG_W (TAG_W)
  ) u_way_select (
    .two_way (s1_two),
    .half    (s1_half),
    .tag     (s1_tag),
    .row_in  (row_cur),
    .row_out (row_new),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      hit <= res.hit;
      way <= res.way;
      evicted <= res.evicted;
    end
  end

  // checks
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted item produced no result");

  a_hit_not_evicted: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted))
    else $error("result reports both hit and eviction");

  a_direct_way_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !two_way_mode) |-> !way)
    else $error("direct-mapped result on way 1");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result during clearing pass");

endmodule

`default_nettype wire

[test/tb_cache_tag_lookup_lfu_unit.sv]
`timescale 1ns / 1ps

module tb_cache_tag_lookup_lfu_unit;

  // geometry at the default sizes
  localparam int LINES = ctl_pkg::CACHE_BYTES_DEFAULT / ctl_pkg::LINE_BYTES_DEFAULT;
  localparam int LINE_BITS = $clog2(LINES);
  localparam int OFFSET_BITS = $clog2(ctl_pkg::LINE_BYTES_DEFAULT);
  localparam int RESULT_LATENCY = 4;
  localparam int REPORT_LIMIT = 10;

  localparam logic MODE_DIRECT = 1'b0;
  localparam logic MODE_TWO_WAY = 1'b1;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [ctl_pkg::ADDR_W-1:0] address;
  logic done;
  logic hit;
  logic way;
  logic evicted;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  cache_tag_lookup_lfu_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .address(address),
    .done(done),
    .hit(hit),
    .way(way),
    .evicted(evicted),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // shadow copy of the tag store and the mode register
  logic tag_mode;
  logic line_ok [LINES];
  logic [31:0] line_tag_copy [LINES];
  logic [ctl_pkg::COUNT_W-1:0] line_uses [LINES];

  ctl_pkg::ctl_result_t lookup_expected [$];

  int mismatch_count;
  int lookups_sent;
  int results_checked;
  int hits_seen;
  int evictions_seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tag store lookup and update for one access, returns the predicted outcome
  function automatic ctl_pkg::ctl_result_t lookup_predict(input logic [31:0] addr);
    int unsigned ways;
    int unsigned set_bits;
    int unsigned set_idx;
    int unsigned base;
    int unsigned victim;
    logic [31:0] tag;
    ctl_pkg::ctl_result_t res;
    ways = tag_mode ? 2 : 1;
    set_bits = tag_mode ? LINE_BITS - 1 : LINE_BITS;
    set_idx = (addr >> OFFSET_BITS) & ((32'd1 << set_bits) - 32'd1);
    tag = addr >> (OFFSET_BITS + set_bits);
    base = set_idx * ways;
    for (int w = 0; w < ways; w++) begin
      if (line_ok[base + w] && line_tag_copy[base + w] == tag) begin
        // use counts stick at all ones
        if (line_uses[base + w] != '1) begin
          line_uses[base + w] = line_uses[base + w] + 1'b1;
        end
        res.hit = 1'b1;
        res.way = 1'(w);
        res.evicted = 1'b0;
        return res;
      end
    end
    // first invalid way, else the less used one (way 0 on a tie)
    victim = ways;
    for (int w = 0; w < ways; w++) begin
      if (!line_ok[base + w] && victim == ways) begin
        victim = w;
      end
    end
    res.evicted = (victim == ways);
    if (victim == ways) begin
      victim = (ways == 2 && line_uses[base + 1] < line_uses[base]) ? 1 : 0;
    end
    line_ok[base + victim] = 1'b1;
    line_tag_copy[base + victim] = tag;
    line_uses[base + victim] = 1;
    res.hit = 1'b0;
    res.way = 1'(victim);
    return res;
  endfunction

  // random address: mostly a few hot sets with a small tag pool so that
  // sets fill up, hit and replace; the rest spread or fully random
  function automatic logic [31:0] make_access_address();
    int unsigned set_bits;
    int unsigned pick;
    logic [31:0] tag;
    logic [31:0] set_idx;
    set_bits = tag_mode ? LINE_BITS - 1 : LINE_BITS;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      return $urandom();
    end
    tag = $urandom_range(0, 4);
    if ($urandom_range(0, 1) == 1) begin
      tag = ~tag;
    end
    if (pick < 70) begin
      set_idx = $urandom_range(0, 7);
    end else begin
      set_idx = $urandom_range(0, (1 << set_bits) - 1);
    end
    return (tag << (OFFSET_BITS + set_bits)) | (set_idx << OFFSET_BITS) |
           32'($urandom_range(0, ctl_pkg::LINE_BYTES_DEFAULT - 1));
  endfunction

  function automatic void note_mismatch(input string what, input logic want_bit,
                                        input logic got_bit);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch on result %0d: %s expected %b got %b",
               results_checked, what, want_bit, got_bit);
    end
  endfunction

  // every strobe is taken at the edge that ends it, so check it there
  always @(posedge clk) begin : check_result
    ctl_pkg::ctl_result_t want;
    if (!rst && done === 1'b1) begin
      if (lookup_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("result with no lookup outstanding: hit %b way %b evicted %b",
                   hit, way, evicted);
        end
      end else begin
        want = lookup_expected.pop_front();
        if (hit !== want.hit) note_mismatch("hit", want.hit, hit);
        if (way !== want.way) note_mismatch("way", want.way, way);
        if (evicted !== want.evicted) note_mismatch("evicted", want.evicted, evicted);
        results_checked++;
        if (want.hit) hits_seen++;
        if (want.evicted) evictions_seen++;
      end
    end
  end

  // one lookup item, preceded by an idle gap at the given odds
  task automatic send_access(input logic [31:0] addr, input int idle_pct);
    ctl_pkg::ctl_result_t predicted;
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      address = $urandom();
      repeat ($urandom_range(0, 3)) @(negedge clk);
      @(negedge clk);
    end
    start = 1'b1;
    address = addr;
    do @(posedge clk); while (busy);
    predicted = lookup_predict(addr);
    lookup_expected = {lookup_expected, predicted};
    lookups_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (lookup_expected.size() != 0) @(negedge clk);
  endtask

  // mode change only with the pipe empty
  task automatic write_mode(input logic mode);
    wait_results_drained();
    repeat (RESULT_LATENCY) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = mode;
    do @(posedge clk); while (!cfg_ready);
    tag_mode = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = $urandom_range(0, 1);
  endtask

  // set 0 fills both ways, hits, then replaces by use count both ways round;
  // set 1 replaces on a tied count
  task automatic test_fill_and_replace();
    write_mode(MODE_TWO_WAY);
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_007F, 0);
    send_access(32'h0000_4000, 0);
    send_access(32'h0000_8000, 0);
    send_access(32'h0000_8010, 0);
    send_access(32'h0000_8020, 0);
    send_access(32'h0000_C000, 0);
    send_access(32'h0000_0080, 0);
    send_access(32'h0000_4080, 0);
    send_access(32'h0000_8080, 0);
  endtask

  task automatic test_address_extremes();
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'h8000_0000, 0);
    send_access(32'h7FFF_FFFF, 0);
    send_access(32'h0000_3F80, 0);
  endtask

  // stores survive a mode change and are read under the other geometry
  task automatic test_mode_switch();
    write_mode(MODE_DIRECT);
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_8000, 0);
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'h0000_7F80, 0);
    send_access(32'h0000_0080, 0);
    send_access(32'h0000_0080, 0);
    write_mode(MODE_TWO_WAY);
    send_access(32'h0000_8000, 0);
    send_access(32'h0000_0000, 0);
  endtask

  task automatic test_random_lookups(input logic mode, input int count, input int idle_pct);
    write_mode(mode);
    for (int i = 0; i < count; i++) begin
      // now and then hold the sender off until the pipe is empty
      if (i % 97 == 50) begin
        wait_results_drained();
      end
      send_access(make_access_address(), idle_pct);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    address = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    tag_mode = MODE_TWO_WAY;
    for (int i = 0; i < LINES; i++) begin
      line_ok[i] = 1'b0;
      line_tag_copy[i] = '0;
      line_uses[i] = '0;
    end
    mismatch_count = 0;
    lookups_sent = 0;
    results_checked = 0;
    hits_seen = 0;
    evictions_seen = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_and_replace();
    test_address_extremes();
    test_mode_switch();
    test_random_lookups(MODE_TWO_WAY, 510, 38);
    test_random_lookups(MODE_DIRECT, 510, 78);
    test_random_lookups(MODE_TWO_WAY, 510, 0);

    wait_results_drained();
    repeat (RESULT_LATENCY * 2) @(posedge clk);
    if (lookup_expected.size() != 0) begin
      mismatch_count++;
    end
    $display("%0d lookups in direct and two-way mode, %0d results checked",
             lookups_sent, results_checked);
    $display("%0d hits, %0d evictions, %0d mismatches",
             hits_seen, evictions_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop, far beyond the slowest passing run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
